>>> design/expires_duration_parser_assert.svh
// Assertion macros for the expires duration parser.
// Each use takes a label, the clock, the active-low reset, a condition and a check.
`ifndef EXPIRES_DURATION_PARSER_ASSERT_SVH
`define EXPIRES_DURATION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define EDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("edp assertion failed");
`define EDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("edp assertion failed");
`else
`define EDP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/edp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edp_pkg;

    localparam int SEC_W    = 63;
    localparam int NUM_UNIT = 6;
    localparam int UCHAR_N  = 7;
    localparam int KSEC_W   = 25;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

    localparam logic [2:0] ACCESS_LEN = 3'd6;
    localparam logic [2:0] PLUS_LEN   = 3'd4;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_S    = 8'h73;

    // names left-justified, first letter in the top byte
    localparam logic [NUM_UNIT-1:0][47:0] UNIT_NAME = {
        {"year", 16'h0000},
        {"month", 8'h00},
        {"day", 24'h000000},
        {"hour", 16'h0000},
        "minute",
        "second"
    };
    localparam logic [NUM_UNIT-1:0][2:0] UNIT_NCHAR = {
        3'd4, 3'd5, 3'd3, 3'd4, 3'd6, 3'd6
    };
    localparam logic [NUM_UNIT-1:0][KSEC_W-1:0] UNIT_SECS = {
        25'd31536000, 25'd2592000, 25'd86400, 25'd3600, 25'd60, 25'd1
    };

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_ACC,
        PH_MID,
        PH_PLUS,
        PH_GAP,
        PH_NUM,
        PH_NUMWS,
        PH_UNIT
    } t_phase;

    typedef logic [UCHAR_N-1:0][7:0] t_uchars;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_umatch;

    typedef struct packed {
        logic [NUM_UNIT-1:0]            ovf;
        logic [NUM_UNIT-1:0][SEC_W-1:0] prod;
    } t_prod;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'd32) : c;
    endfunction

    function automatic logic [7:0] access_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = "a";
            3'd1:    r = "c";
            3'd2:    r = "c";
            3'd3:    r = "e";
            3'd4:    r = "s";
            3'd5:    r = "s";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] plus_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = "p";
            3'd1:    r = "l";
            3'd2:    r = "u";
            3'd3:    r = "s";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // saturate at SEC_MAX
    function automatic logic [SEC_W-1:0] add_digit(input logic [SEC_W-1:0] num,
                                                   input logic [7:0] c);
        logic [SEC_W+3:0] t;
        t = (SEC_W+4)'({num, 3'b000}) + (SEC_W+4)'({num, 1'b0})
          + (SEC_W+4)'(c - CH_ZERO);
        return (t > (SEC_W+4)'(SEC_MAX)) ? SEC_MAX : t[SEC_W-1:0];
    endfunction

    function automatic t_umatch unit_lookup(input t_uchars chars, input logic [3:0] cnt);
        t_umatch    m;
        logic       ok;
        logic [2:0] len;
        m = '{hit: 1'b0, idx: 3'd0};
        for (int u = 0; u < NUM_UNIT; u++) begin
            len = UNIT_NCHAR[u];
            ok  = (cnt == {1'b0, len})
               || ((cnt == ({1'b0, len} + 4'd1)) && (chars[len] == CH_S));
            for (int k = 0; k < 6; k++) begin
                if ((3'(k) < len) && (chars[k] != UNIT_NAME[u][47-8*k -: 8])) begin
                    ok = 1'b0;
                end
            end
            if (ok && !m.hit) begin
                m.hit = 1'b1;
                m.idx = 3'(u);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/edp_unit_mult.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-stage constant multiply of the number by every unit's seconds.
module edp_unit_mult (
    input  wire logic                       i_clk,
    input  wire logic [edp_pkg::SEC_W-1:0]  i_number,
    output edp_pkg::t_prod                  o_prod
);

    localparam int LO_W   = 32 + edp_pkg::KSEC_W;
    localparam int HI_W   = edp_pkg::SEC_W - 32 + edp_pkg::KSEC_W;
    localparam int FULL_W = edp_pkg::SEC_W + edp_pkg::KSEC_W;

    logic [edp_pkg::NUM_UNIT-1:0][LO_W-1:0] r_lo;
    logic [edp_pkg::NUM_UNIT-1:0][HI_W-1:0] r_hi;
    edp_pkg::t_prod                         r_prod;
    logic [edp_pkg::NUM_UNIT-1:0][FULL_W-1:0] n_full;

    always_ff @(posedge i_clk) begin
        for (int u = 0; u < edp_pkg::NUM_UNIT; u++) begin
            r_lo[u] <= LO_W'(i_number[31:0]) * LO_W'(edp_pkg::UNIT_SECS[u]);
            r_hi[u] <= HI_W'(i_number[edp_pkg::SEC_W-1:32]) * HI_W'(edp_pkg::UNIT_SECS[u]);
        end
    end

    always_comb begin
        for (int u = 0; u < edp_pkg::NUM_UNIT; u++) begin
            n_full[u] = {r_hi[u], 32'h0} + FULL_W'(r_lo[u]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int u = 0; u < edp_pkg::NUM_UNIT; u++) begin
            r_prod.ovf[u]  <= |n_full[u][FULL_W-1:edp_pkg::SEC_W];
            r_prod.prod[u] <= n_full[u][edp_pkg::SEC_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> design/expires_duration_parser.sv
// Expires duration parser: reads a duration string such as
// "access plus 1 month 2 days" one character per item and gives its length in seconds.
// Input channel: i_in_valid, i_ch, i_last, back-pressure on o_in_stall. An item is
// taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid, o_valid_res, o_seconds, back-pressure on i_out_stall.
// Exactly one result follows each item with i_last set; other items give none.
// Throughput is one item per cycle while o_in_stall is low. The result is loaded
// into the output register when its last item is taken. Each unit product comes
// from a two-stage constant multiplier that trails the number register; a unit name
// has at least three letters, so the product is ready by the time the unit closes.
// While a result waits under i_out_stall, o_in_stall is raised; otherwise items
// keep flowing and a new result may load as the old one leaves.
// A zero byte ends the string; items after it up to the last are dropped.
// Reset (synchronous, active low) empties the output and returns the parser to
// the start of a string; the parser also returns there after each last item.
`timescale 1ns / 1ps
`default_nettype none
`include "expires_duration_parser_assert.svh"

module expires_duration_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [7:0]                 i_ch,
    input  wire logic                       i_last,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output logic                            o_valid_res,
    output logic [edp_pkg::SEC_W-1:0]       o_seconds,
    input  wire logic                       i_out_stall
);

    edp_pkg::t_phase              r_phase, n_phase;
    logic [2:0]                   r_kidx, n_kidx;
    logic [edp_pkg::SEC_W-1:0]    r_num, n_num;
    edp_pkg::t_uchars             r_chars, n_chars;
    logic [3:0]                   r_cnt, n_cnt;
    logic [edp_pkg::SEC_W-1:0]    r_total, n_total;
    logic                         r_seen, n_seen;
    logic                         r_failed, n_failed;
    logic                         r_ended, n_ended;

    logic                         r_out_valid;
    logic                         r_res;
    logic [edp_pkg::SEC_W-1:0]    r_sec;

    logic                         wr_en;
    logic [2:0]                   wr_idx;
    logic [7:0]                   wr_data;

    logic                         acc;
    logic [7:0]                   lc;
    edp_pkg::t_prod               prod;
    edp_pkg::t_umatch             fm, gm;
    logic [edp_pkg::SEC_W:0]      fsum, gsum;
    logic                         f_ok, g_ok;
    logic                         fin_ok;
    logic [edp_pkg::SEC_W-1:0]    fin_sec;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign acc        = i_in_valid & ~o_in_stall;
    assign lc         = edp_pkg::to_lower(i_ch);

    edp_unit_mult u_mult (
        .i_clk    (i_clk),
        .i_number (r_num),
        .o_prod   (prod)
    );

    // unit close inside the string, on the current unit letters
    assign fm   = edp_pkg::unit_lookup(r_chars, r_cnt);
    assign fsum = {1'b0, r_total} + {1'b0, prod.prod[fm.idx]};
    assign f_ok = fm.hit & ~prod.ovf[fm.idx] & ~fsum[edp_pkg::SEC_W];

    // unit close at the end of the string, including this item's letter
    assign gm   = edp_pkg::unit_lookup(n_chars, n_cnt);
    assign gsum = {1'b0, r_total} + {1'b0, prod.prod[gm.idx]};
    assign g_ok = gm.hit & ~prod.ovf[gm.idx] & ~gsum[edp_pkg::SEC_W];

    // next state
    always_comb begin
        edp_pkg::t_phase ph;
        logic            go;
        n_phase  = r_phase;
        n_kidx   = r_kidx;
        n_num    = r_num;
        n_cnt    = r_cnt;
        n_total  = r_total;
        n_seen   = r_seen;
        n_failed = r_failed;
        n_ended  = r_ended;
        wr_en    = 1'b0;
        wr_idx   = r_cnt[2:0];
        wr_data  = lc;
        ph       = r_phase;
        go       = 1'b1;
        if (r_ended || r_failed) begin
            go = 1'b0;
        end else if (i_ch == 8'h00) begin
            n_ended = 1'b1;
            go      = 1'b0;
        end
        if (go && (ph == edp_pkg::PH_LEAD)) begin
            if (edp_pkg::is_ws(i_ch)) begin
                go = 1'b0;
            end else begin
                ph     = edp_pkg::PH_ACC;
                n_kidx = 3'd0;
            end
        end
        if (go && (ph == edp_pkg::PH_MID)) begin
            if (edp_pkg::is_ws(i_ch)) begin
                go = 1'b0;
            end else begin
                ph     = edp_pkg::PH_PLUS;
                n_kidx = 3'd0;
            end
        end
        if (go) begin
            n_phase = ph;
            case (ph)
                edp_pkg::PH_ACC: begin
                    if (n_kidx >= edp_pkg::ACCESS_LEN) begin
                        if (edp_pkg::is_ws(i_ch)) n_phase = edp_pkg::PH_MID;
                        else n_failed = 1'b1;
                    end else if (lc == edp_pkg::access_char(n_kidx)) begin
                        n_kidx = n_kidx + 3'd1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                edp_pkg::PH_PLUS: begin
                    if (n_kidx >= edp_pkg::PLUS_LEN) begin
                        if (edp_pkg::is_ws(i_ch)) n_phase = edp_pkg::PH_GAP;
                        else n_failed = 1'b1;
                    end else if (lc == edp_pkg::plus_char(n_kidx)) begin
                        n_kidx = n_kidx + 3'd1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                edp_pkg::PH_GAP: begin
                    if (edp_pkg::is_digit(i_ch)) begin
                        n_num   = edp_pkg::add_digit('0, i_ch);
                        n_phase = edp_pkg::PH_NUM;
                    end else if (!edp_pkg::is_ws(i_ch)) begin
                        n_failed = 1'b1;
                    end
                end
                edp_pkg::PH_NUM: begin
                    if (edp_pkg::is_digit(i_ch)) begin
                        n_num = edp_pkg::add_digit(r_num, i_ch);
                    end else if (edp_pkg::is_ws(i_ch)) begin
                        n_phase = edp_pkg::PH_NUMWS;
                    end else if (edp_pkg::is_alpha(i_ch)) begin
                        wr_en   = 1'b1;
                        wr_idx  = 3'd0;
                        n_cnt   = 4'd1;
                        n_phase = edp_pkg::PH_UNIT;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                edp_pkg::PH_NUMWS: begin
                    if (edp_pkg::is_alpha(i_ch)) begin
                        wr_en   = 1'b1;
                        wr_idx  = 3'd0;
                        n_cnt   = 4'd1;
                        n_phase = edp_pkg::PH_UNIT;
                    end else if (!edp_pkg::is_ws(i_ch)) begin
                        n_failed = 1'b1;
                    end
                end
                edp_pkg::PH_UNIT: begin
                    if (edp_pkg::is_alpha(i_ch)) begin
                        wr_en = (r_cnt < 4'(edp_pkg::UCHAR_N));
                        if (r_cnt <= 4'(edp_pkg::UCHAR_N)) n_cnt = r_cnt + 4'd1;
                    end else if (!f_ok) begin
                        n_failed = 1'b1;
                    end else begin
                        n_total = fsum[edp_pkg::SEC_W-1:0];
                        n_seen  = 1'b1;
                        if (edp_pkg::is_ws(i_ch)) begin
                            n_phase = edp_pkg::PH_GAP;
                        end else if (edp_pkg::is_digit(i_ch)) begin
                            n_num   = edp_pkg::add_digit('0, i_ch);
                            n_phase = edp_pkg::PH_NUM;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
        n_chars = r_chars;
        if (wr_en) n_chars[wr_idx] = wr_data;
    end

    // result of the string as it stands after this item
    always_comb begin
        fin_ok  = 1'b0;
        fin_sec = '0;
        if (!n_failed) begin
            case (n_phase)
                edp_pkg::PH_GAP: begin
                    fin_ok  = n_seen;
                    fin_sec = n_seen ? n_total : '0;
                end
                edp_pkg::PH_UNIT: begin
                    fin_ok  = g_ok;
                    fin_sec = g_ok ? gsum[edp_pkg::SEC_W-1:0] : '0;
                end
                default: begin
                    fin_ok  = 1'b0;
                    fin_sec = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= edp_pkg::PH_LEAD;
            r_kidx   <= 3'd0;
            r_num    <= '0;
            r_cnt    <= 4'd0;
            r_total  <= '0;
            r_seen   <= 1'b0;
            r_failed <= 1'b0;
            r_ended  <= 1'b0;
        end else if (acc) begin
            if (i_last) begin
                r_phase  <= edp_pkg::PH_LEAD;
                r_kidx   <= 3'd0;
                r_num    <= '0;
                r_cnt    <= 4'd0;
                r_total  <= '0;
                r_seen   <= 1'b0;
                r_failed <= 1'b0;
                r_ended  <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_kidx   <= n_kidx;
                r_num    <= n_num;
                r_cnt    <= n_cnt;
                r_total  <= n_total;
                r_seen   <= n_seen;
                r_failed <= n_failed;
                r_ended  <= n_ended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            r_chars[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc && i_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_last) begin
            r_res <= fin_ok;
            r_sec <= fin_sec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_res;
    assign o_seconds   = r_sec;

    `EDP_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && !r_res, r_sec == '0)
    `EDP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, acc && i_last, r_out_valid)
    `EDP_ASSERT_NEXT(a_ended_holds, i_clk, i_rst_n, acc && !i_last && r_ended, r_ended)
    `EDP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, acc && i_last, !r_failed && !r_seen)

endmodule

`default_nettype wire
